// ===== hw/rtl/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types, constants and command codes of the polynomial bisection
// root finder.
// ----------------------------------------------------------------------------
package pbr_pkg;

    // Field widths
    localparam int DATA_W    = 32;   // signed fixed point values
    localparam int ACC_W     = 48;   // Horner accumulator
    localparam int TOL_W     = 24;   // relative tolerance, Q0.24
    localparam int CAP_W     = 7;    // step counter / cap
    localparam int TERM_W    = 3;    // Horner term index, covers degree 1..5
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 4;

    // Default parameter values
    localparam int DEGREE_DEF    = 4;
    localparam int FRAC_BITS_DEF = 24;

    // Step cap limits
    localparam logic [CAP_W-1:0] CAP_MAX = 7'd64;
    localparam logic [CAP_W-1:0] CAP_MIN = 7'd1;

    // Accumulator saturation bounds, +-(2^47 - 1)
    localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_NEG_MAX = {1'b1, {(ACC_W-2){1'b0}}, 1'b1};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LEAD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONSTANT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REL_TOLERANCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_CAP = 3'd6;

    // Register reset values
    localparam logic [DATA_W-1:0] COEF_LEAD_RST     = 32'h0300_0000;  //  3.0
    localparam logic [DATA_W-1:0] COEF_CUBIC_RST    = 32'hF800_0000;  // -8.0
    localparam logic [DATA_W-1:0] COEF_SQUARE_RST   = 32'h0200_0000;  //  2.0
    localparam logic [DATA_W-1:0] COEF_LINEAR_RST   = 32'h0500_0000;  //  5.0
    localparam logic [DATA_W-1:0] COEF_CONSTANT_RST = 32'hFF00_0000;  // -1.0
    localparam logic [TOL_W-1:0]  REL_TOLERANCE_RST = 24'd17;
    localparam logic [CAP_W-1:0]  ITERATION_CAP_RST = 7'd48;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;   // take request, start eval at x0
    localparam logic [OP_W-1:0] OP_MUL_LO  = 4'd2;   // low partial product
    localparam logic [OP_W-1:0] OP_MUL_HI  = 4'd3;   // high partial product
    localparam logic [OP_W-1:0] OP_COMB    = 4'd4;   // join, rescale, saturate
    localparam logic [OP_W-1:0] OP_ACC     = 4'd5;   // add coefficient, saturate
    localparam logic [OP_W-1:0] OP_SAVE_F0 = 4'd6;   // keep sign of f(x0)
    localparam logic [OP_W-1:0] OP_MID     = 4'd7;   // form midpoint, start eval
    localparam logic [OP_W-1:0] OP_UPDATE  = 4'd8;   // move one interval end
    localparam logic [OP_W-1:0] OP_TOL     = 4'd9;   // width and tolerance product
    localparam logic [OP_W-1:0] OP_CMP     = 4'd10;  // latch stop test
    localparam logic [OP_W-1:0] OP_OUT     = 4'd11;  // load result register

    // Request and result payloads
    typedef struct packed {
        logic signed [DATA_W-1:0] left_end;
        logic signed [DATA_W-1:0] right_end;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] root_estimate;
        logic [CAP_W-1:0]         step_count;
        logic                     converged;
    } t_out;

    // Configuration registers
    typedef struct packed {
        logic signed [DATA_W-1:0] coef_lead;
        logic signed [DATA_W-1:0] coef_cubic;
        logic signed [DATA_W-1:0] coef_square;
        logic signed [DATA_W-1:0] coef_linear;
        logic signed [DATA_W-1:0] coef_constant;
        logic [TOL_W-1:0]         rel_tolerance;
        logic [CAP_W-1:0]         iteration_cap;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TERM_W-1:0] term;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic tol_met;
        logic last_step;
    } t_dp_sts;

endpackage

// ===== hw/rtl/pbr_cfg.sv =====
// ----------------------------------------------------------------------------
// pbr_cfg
// Configuration register file: coefficients, tolerance and step cap.
// ----------------------------------------------------------------------------
module pbr_cfg
    import pbr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_lead     <= COEF_LEAD_RST;
            r_cfg.coef_cubic    <= COEF_CUBIC_RST;
            r_cfg.coef_square   <= COEF_SQUARE_RST;
            r_cfg.coef_linear   <= COEF_LINEAR_RST;
            r_cfg.coef_constant <= COEF_CONSTANT_RST;
            r_cfg.rel_tolerance <= REL_TOLERANCE_RST;
            r_cfg.iteration_cap <= ITERATION_CAP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_COEF_LEAD:     r_cfg.coef_lead     <= i_cfg_wdata;
                REG_COEF_CUBIC:    r_cfg.coef_cubic    <= i_cfg_wdata;
                REG_COEF_SQUARE:   r_cfg.coef_square   <= i_cfg_wdata;
                REG_COEF_LINEAR:   r_cfg.coef_linear   <= i_cfg_wdata;
                REG_COEF_CONSTANT: r_cfg.coef_constant <= i_cfg_wdata;
                REG_REL_TOLERANCE: r_cfg.rel_tolerance <= i_cfg_wdata[TOL_W-1:0];
                REG_ITERATION_CAP: r_cfg.iteration_cap <= i_cfg_wdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/pbr_dp.sv =====
// ----------------------------------------------------------------------------
// pbr_dp
// Datapath: interval ends, Horner accumulator on one shared 24x32
// multiplier, stop test and result register.
// ----------------------------------------------------------------------------
module pbr_dp
    import pbr_pkg::*;
#(
    parameter int DEGREE    = DEGREE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_in     i_in_data,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_out    o_out_data
);

    localparam int MUL_A_W = TOL_W;              // multiplier operand A
    localparam int MUL_W   = MUL_A_W + DATA_W;   // multiplier result
    localparam int PROD_W  = MUL_W + MUL_A_W;    // joined Horner product
    localparam int SUM_W   = ACC_W + 1;

    localparam logic signed [SUM_W-1:0]  SUM_HI  = {1'b0, ACC_POS_MAX};
    localparam logic signed [SUM_W-1:0]  SUM_LO  = {1'b1, ACC_NEG_MAX};
    localparam logic [PROD_W-1:0]        PROD_HI = {{(PROD_W-ACC_W){1'b0}}, ACC_POS_MAX};
    localparam logic [DATA_W-1:0]        ONE_FX  = DATA_W'(1) << FRAC_BITS;

    // Coefficient of x^k, zero above the fourth power
    function automatic logic signed [DATA_W-1:0] coef_sel(
        input t_cfg              cfg,
        input logic [TERM_W-1:0] k
    );
        logic signed [DATA_W-1:0] c;
        case (k)
            3'd0:    c = cfg.coef_constant;
            3'd1:    c = cfg.coef_linear;
            3'd2:    c = cfg.coef_square;
            3'd3:    c = cfg.coef_cubic;
            3'd4:    c = cfg.coef_lead;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Magnitude of a 32 bit signed value, fits 32 bits unsigned
    function automatic logic [DATA_W-1:0] abs_data(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    // Working registers
    logic signed [DATA_W-1:0] r_x0, r_x1, r_mid;
    logic [DATA_W-1:0]        r_exabs;
    logic                     r_exneg;
    logic signed [ACC_W-1:0]  r_p;
    logic signed [ACC_W-1:0]  r_t;
    logic                     r_neg;
    logic [MUL_W-1:0]         r_plo, r_phi, r_rhs;
    logic                     r_f0_neg, r_f0_nz;
    logic [CAP_W-1:0]         r_steps, r_cap;
    logic [DATA_W-1:0]        r_w;
    logic                     r_conv;
    t_out                     r_out;

    logic signed [DATA_W-1:0] coef_k, coef_top;
    logic [ACC_W-1:0]         p_abs;
    logic [MUL_A_W-1:0]       mul_a;
    logic [DATA_W-1:0]        mul_b;
    logic [MUL_W-1:0]         mul_y;
    logic [DATA_W:0]          mid_sum;
    logic signed [DATA_W-1:0] mid;
    logic [DATA_W-1:0]        mag1;
    logic [PROD_W-1:0]        prod_full, prod_shift;
    logic [ACC_W-1:0]         prod_mag;
    logic signed [ACC_W-1:0]  prod_term;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic [DATA_W:0]          diff, diff_abs;
    logic                     same_sign;
    logic [CAP_W-1:0]         cap_eff;

    assign coef_k   = coef_sel(i_cfg, i_cmd.term);
    assign coef_top = coef_sel(i_cfg, TERM_W'(DEGREE));
    assign p_abs    = r_p[ACC_W-1] ? (~r_p + 1'b1) : r_p;

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_MUL_LO: begin
                mul_a = p_abs[MUL_A_W-1:0];
                mul_b = r_exabs;
            end
            OP_MUL_HI: begin
                mul_a = p_abs[ACC_W-1:MUL_A_W];
                mul_b = r_exabs;
            end
            OP_TOL: begin
                mul_a = i_cfg.rel_tolerance;
                mul_b = mag1;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_y = {{DATA_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    // Midpoint, floor of the 33 bit sum over two
    assign mid_sum = {r_x0[DATA_W-1], r_x0} + {r_x1[DATA_W-1], r_x1};
    assign mid     = mid_sum[DATA_W:1];

    // Right end magnitude, 1.0 when it is zero
    assign mag1 = (r_x1 == '0) ? ONE_FX : abs_data(r_x1);

    // Join partial products, rescale, saturate the magnitude, restore sign
    assign prod_full  = {r_phi, {MUL_A_W{1'b0}}} + {{MUL_A_W{1'b0}}, r_plo};
    assign prod_shift = prod_full >> FRAC_BITS;
    assign prod_mag   = (prod_shift > PROD_HI) ? ACC_POS_MAX : prod_shift[ACC_W-1:0];
    assign prod_term  = r_neg ? -$signed(prod_mag) : $signed(prod_mag);

    // Add coefficient with symmetric saturation
    always_comb begin
        acc_sum = $signed({r_t[ACC_W-1], r_t})
                + $signed({{(SUM_W-DATA_W){coef_k[DATA_W-1]}}, coef_k});
        if (acc_sum > SUM_HI) begin
            acc_sat = ACC_POS_MAX;
        end else if (acc_sum < SUM_LO) begin
            acc_sat = ACC_NEG_MAX;
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // Interval width
    assign diff     = {r_x1[DATA_W-1], r_x1} - {r_x0[DATA_W-1], r_x0};
    assign diff_abs = diff[DATA_W] ? (~diff + 1'b1) : diff;

    // f(mid) and f(x0) strictly of one sign
    assign same_sign = r_f0_nz && (r_p != '0) && (r_f0_neg == r_p[ACC_W-1]);

    // Step cap clamped to 1..64
    always_comb begin
        if (i_cfg.iteration_cap == '0) begin
            cap_eff = CAP_MIN;
        end else if (i_cfg.iteration_cap > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = i_cfg.iteration_cap;
        end
    end

    // Register updates per operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_cap   <= CAP_MIN;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_x0    <= i_in_data.left_end;
                    r_x1    <= i_in_data.right_end;
                    r_exabs <= abs_data(i_in_data.left_end);
                    r_exneg <= i_in_data.left_end[DATA_W-1];
                    r_p     <= ACC_W'(coef_top);
                    r_steps <= '0;
                    r_cap   <= cap_eff;
                end
                OP_MUL_LO: begin
                    r_plo <= mul_y;
                    r_neg <= r_p[ACC_W-1] ^ r_exneg;
                end
                OP_MUL_HI: begin
                    r_phi <= mul_y;
                end
                OP_COMB: begin
                    r_t <= prod_term;
                end
                OP_ACC: begin
                    r_p <= acc_sat;
                end
                OP_SAVE_F0: begin
                    r_f0_neg <= r_p[ACC_W-1];
                    r_f0_nz  <= (r_p != '0);
                end
                OP_MID: begin
                    r_mid   <= mid;
                    r_exabs <= abs_data(mid);
                    r_exneg <= mid[DATA_W-1];
                    r_p     <= ACC_W'(coef_top);
                end
                OP_UPDATE: begin
                    if (same_sign) begin
                        r_x0     <= r_mid;
                        r_f0_neg <= r_p[ACC_W-1];
                    end else begin
                        r_x1 <= r_mid;
                    end
                    r_steps <= r_steps + 1'b1;
                end
                OP_TOL: begin
                    r_w   <= diff_abs[DATA_W-1:0];
                    r_rhs <= mul_y;
                end
                OP_CMP: begin
                    r_conv <= o_sts.tol_met;
                end
                OP_OUT: begin
                    r_out.root_estimate <= r_mid;
                    r_out.step_count    <= r_steps;
                    r_out.converged     <= r_conv;
                end
                default: ;
            endcase
        end
    end

    // Status back to the controller
    assign o_sts.tol_met   = {r_w, {TOL_W{1'b0}}} < r_rhs;
    assign o_sts.last_step = (r_steps == r_cap);
    assign o_out_data      = r_out;

    // The step counter never runs past the clamped cap
    a_steps_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steps <= r_cap))
        else $error("step counter beyond cap");

    // Accumulator stays inside the symmetric saturation range
    a_acc_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ACC) |=> (r_p != {1'b1, {(ACC_W-1){1'b0}}}))
        else $error("accumulator hit the asymmetric minimum");

endmodule

// ===== hw/rtl/pbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbr_ctrl
// Controller: sequences Horner terms and bisection steps, owns the
// request/result handshakes.
// ----------------------------------------------------------------------------
module pbr_ctrl
    import pbr_pkg::*;
#(
    parameter int DEGREE = DEGREE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_MLO  = 4'd1;
    localparam logic [ST_W-1:0] ST_MHI  = 4'd2;
    localparam logic [ST_W-1:0] ST_COMB = 4'd3;
    localparam logic [ST_W-1:0] ST_ACC  = 4'd4;
    localparam logic [ST_W-1:0] ST_F0   = 4'd5;
    localparam logic [ST_W-1:0] ST_MID  = 4'd6;
    localparam logic [ST_W-1:0] ST_UPD  = 4'd7;
    localparam logic [ST_W-1:0] ST_TOL  = 4'd8;
    localparam logic [ST_W-1:0] ST_CMP  = 4'd9;
    localparam logic [ST_W-1:0] ST_FIN  = 4'd10;

    localparam logic [TERM_W-1:0] TERM_TOP = TERM_W'(DEGREE - 1);

    logic [ST_W-1:0]   r_state, n_state;
    logic [TERM_W-1:0] r_term, n_term;
    logic              r_ev0, n_ev0;        // evaluating at x0, not at mid
    logic              r_out_valid, n_out_valid;
    logic [OP_W-1:0]   op;

    // Next state and datapath operation
    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_ev0       = r_ev0;
        n_out_valid = r_out_valid;
        op          = OP_NONE;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_term  = TERM_TOP;
                    n_ev0   = 1'b1;
                    n_state = ST_MLO;
                end
            end
            ST_MLO: begin
                op      = OP_MUL_LO;
                n_state = ST_MHI;
            end
            ST_MHI: begin
                op      = OP_MUL_HI;
                n_state = ST_COMB;
            end
            ST_COMB: begin
                op      = OP_COMB;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                op = OP_ACC;
                if (r_term == '0) begin
                    n_state = r_ev0 ? ST_F0 : ST_UPD;
                end else begin
                    n_term  = r_term - 1'b1;
                    n_state = ST_MLO;
                end
            end
            ST_F0: begin
                op      = OP_SAVE_F0;
                n_state = ST_MID;
            end
            ST_MID: begin
                op      = OP_MID;
                n_term  = TERM_TOP;
                n_ev0   = 1'b0;
                n_state = ST_MLO;
            end
            ST_UPD: begin
                op      = OP_UPDATE;
                n_state = ST_TOL;
            end
            ST_TOL: begin
                op      = OP_TOL;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                op = OP_CMP;
                if (i_sts.tol_met || i_sts.last_step) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_MID;
                end
            end
            ST_FIN: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_term      <= '0;
            r_ev0       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_ev0       <= n_ev0;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = op;
    assign o_cmd.term  = r_term;

    // An accepted request always starts the first Horner term
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MLO))
        else $error("request accepted without starting evaluation");

    // Finishing presents a result and frees the input side
    a_fin_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && (!r_out_valid || i_out_ready))
        |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished item not presented");

    // Term index stays below the degree
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_term < TERM_W'(DEGREE)))
        else $error("Horner term index out of range");

endmodule

// ===== hw/rtl/polynomial_bisection_root_finder.sv =====
// ----------------------------------------------------------------------------
// polynomial_bisection_root_finder
// Bisection root search of a polynomial evaluated by Horner's rule in Q8.24.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (i_in_valid / o_in_ready / i_in_data) carries an interval
//   [left_end, right_end]; the result channel (o_out_valid / i_out_ready /
//   o_out_data) returns the last midpoint, the step count and whether the
//   relative tolerance was met. One result per request, in order.
//   Coefficients, tolerance and step cap are written through the plain write
//   port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata); the user must do so only
//   while the block is idle, as the block itself does not enforce it.
// Operation (DEGREE = 4)
//   Each Horner term runs on the single 24x32 multiplier (low and high
//   partial products, rescale, coefficient add). f(left_end) is found once;
//   each bisection step then evaluates the midpoint. A search runs n steps,
//   n being 1..cap, cap at most 64. A new request is taken the cycle after
//   the result is loaded into the output register.
// Reset and stalls
//   Reset restores the register defaults and empties the result register.
//   A stalled receiver holds the result; the next item then runs and waits
//   in its final state until the result register is free.
// ----------------------------------------------------------------------------
module polynomial_bisection_root_finder
    import pbr_pkg::*;
#(
    parameter int DEGREE    = DEGREE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers
    pbr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Sequencer
    pbr_ctrl #(
        .DEGREE (DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic
    pbr_dp #(
        .DEGREE    (DEGREE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polynomial bisection root finder. Intervals are
// sent as requests and every search is predicted here from the register
// values in force. Each result is then compared field by field, in order.
// ----------------------------------------------------------------------------
module tb
    import pbr_pkg::*;
();

    localparam int     WATCHDOG_LIMIT = 8000;
    localparam int     TAIL_CYCLES    = 1400;
    localparam int     MAX_REPORTS    = 10;
    localparam int     FRAC           = FRAC_BITS_DEF;
    localparam int     SHORT_CAP      = 24;
    localparam longint ACC_LIMIT      = 64'sh0000_7FFF_FFFF_FFFF;

    // Handy Q8.24 values
    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0100_0000;
    localparam logic signed [DATA_W-1:0] Q_EIGHT = 32'sh0800_0000;
    localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;

    // Register copy used for prediction
    t_cfg regs_now = '{
        coef_lead:     COEF_LEAD_RST,
        coef_cubic:    COEF_CUBIC_RST,
        coef_square:   COEF_SQUARE_RST,
        coef_linear:   COEF_LINEAR_RST,
        coef_constant: COEF_CONSTANT_RST,
        rel_tolerance: REL_TOLERANCE_RST,
        iteration_cap: ITERATION_CAP_RST
    };

    t_out roots_due[$];
    int   n_errors   = 0;
    int   stall_left = 0;
    bit   idling     = 1'b1;

    polynomial_bisection_root_finder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Symmetric saturation of the Horner accumulator
    function automatic longint clamp_acc(longint v);
        if (v > ACC_LIMIT)
            return ACC_LIMIT;
        if (v < -ACC_LIMIT)
            return -ACC_LIMIT;
        return v;
    endfunction

    // (p * x) >> 24, magnitude truncated, then saturated
    function automatic longint fixed_mul(longint p, longint x);
        logic            neg;
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        neg = (p < 0) != (x < 0);
        a = (p < 0) ? -p : p;
        b = (x < 0) ? -x : x;
        // split keeps both partial products inside 64 bits
        m = (a >> FRAC) * b + (((a & 64'h00FF_FFFF) * b) >> FRAC);
        if (m > ACC_LIMIT)
            m = ACC_LIMIT;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint horner(longint x, t_cfg cfg);
        longint coef [4];
        longint acc;
        int     k;
        coef[0] = longint'(cfg.coef_constant);
        coef[1] = longint'(cfg.coef_linear);
        coef[2] = longint'(cfg.coef_square);
        coef[3] = longint'(cfg.coef_cubic);
        acc = clamp_acc(longint'(cfg.coef_lead));
        for (k = 3; k >= 0; k--)
            acc = clamp_acc(fixed_mul(acc, x) + coef[k]);
        return acc;
    endfunction

    // Full bisection search for one interval
    function automatic t_out find_root(t_in req, t_cfg cfg);
        longint          x0;
        longint          x1;
        longint          mid;
        longint          f_mid;
        longint          f_left;
        longint          w;
        longint unsigned mag;
        longint unsigned lhs;
        longint unsigned rhs;
        int              cap;
        int              steps;
        logic            conv;
        t_out            res;
        x0    = longint'(req.left_end);
        x1    = longint'(req.right_end);
        cap   = int'(cfg.iteration_cap);
        steps = 0;
        mid   = 0;
        conv  = 1'b0;
        if (cap == 0)
            cap = 1;
        if (cap > int'(CAP_MAX))
            cap = int'(CAP_MAX);
        while (steps < cap && !conv) begin
            mid    = (x0 + x1) >>> 1;
            f_mid  = horner(mid, cfg);
            f_left = horner(x0, cfg);
            if ((f_mid > 0 && f_left > 0) || (f_mid < 0 && f_left < 0))
                x0 = mid;
            else
                x1 = mid;
            steps++;
            w = x1 - x0;
            if (w < 0)
                w = -w;
            // zero right end turns the test absolute
            mag = (x1 == 0) ? (64'd1 << FRAC) : ((x1 < 0) ? -x1 : x1);
            lhs = w;
            lhs = lhs << TOL_W;
            rhs = 64'(cfg.rel_tolerance);
            rhs = rhs * mag;
            if (lhs < rhs)
                conv = 1'b1;
        end
        res.root_estimate = mid[DATA_W-1:0];
        res.step_count    = steps[CAP_W-1:0];
        res.converged     = conv;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    // Anywhere in +-8.0
    function automatic logic signed [DATA_W-1:0] near_q();
        return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
    endfunction

    function automatic logic [DATA_W-1:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return ($urandom_range(0, 16) - 8) << FRAC;
            2: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One register write; entered and left at a falling edge
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_COEF_LEAD:     regs_now.coef_lead     = value;
            REG_COEF_CUBIC:    regs_now.coef_cubic    = value;
            REG_COEF_SQUARE:   regs_now.coef_square   = value;
            REG_COEF_LINEAR:   regs_now.coef_linear   = value;
            REG_COEF_CONSTANT: regs_now.coef_constant = value;
            REG_REL_TOLERANCE: regs_now.rel_tolerance = value[TOL_W-1:0];
            REG_ITERATION_CAP: regs_now.iteration_cap = value[CAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_coefs(input logic [DATA_W-1:0] value, input bit scatter);
        logic [CFG_IDX_W-1:0] idx;
        for (idx = REG_COEF_LEAD; idx <= REG_COEF_CONSTANT; idx++)
            set_reg(idx, scatter ? rand_coef() : value);
    endtask

    // Send one request and log its expected result once taken
    task automatic send_interval(input logic signed [DATA_W-1:0] left_q,
                                 input logic signed [DATA_W-1:0] right_q);
        t_in req;
        req.left_end  = left_q;
        req.right_end = right_q;
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        roots_due.push_back(find_root(req, regs_now));
        @(negedge i_clk);
    endtask

    // Let every outstanding request finish before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        while (roots_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (roots_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("tb: result with no request outstanding: root %h steps %0d conv %0b",
                             o_out_data.root_estimate, o_out_data.step_count,
                             o_out_data.converged);
            end else begin
                want = roots_due.pop_front();
                if (o_out_data.root_estimate !== want.root_estimate ||
                    o_out_data.step_count !== want.step_count ||
                    o_out_data.converged !== want.converged) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("tb: mismatch: root %h/%h steps %0d/%0d conv %0b/%0b (exp/act)",
                                 want.root_estimate, o_out_data.root_estimate,
                                 want.step_count, o_out_data.step_count,
                                 want.converged, o_out_data.converged);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset polynomial 3x^4 - 8x^3 + 2x^2 + 5x - 1 on assorted intervals
    task automatic test_default_polynomial();
        send_interval('0, Q_ONE);
        send_interval(Q_ONE, 2 * Q_ONE);
        send_interval(-Q_ONE, '0);
        send_interval('0, '0);
        send_interval(2 * Q_ONE, Q_ONE);        // reversed
        send_interval(Q_MIN, Q_MAX);
        send_interval(Q_MAX, Q_MAX);
        send_interval(Q_MIN, Q_MIN);
        send_interval(-(Q_ONE >>> 1), 3 * Q_ONE);
    endtask

    // Tolerance and cap corners, saturating and zero polynomials
    task automatic test_register_corners();
        drain();
        set_reg(REG_REL_TOLERANCE, '0);          // never converges
        set_reg(REG_ITERATION_CAP, 32'd5);
        send_interval('0, Q_ONE);
        send_interval(Q_MIN, Q_MAX);
        drain();
        set_reg(REG_ITERATION_CAP, '0);          // behaves as one step
        send_interval(Q_ONE, -Q_ONE);
        drain();
        set_reg(REG_ITERATION_CAP, 32'h7F);      // clipped to the maximum
        send_interval('0, Q_ONE);
        drain();
        set_reg(REG_ITERATION_CAP, DATA_W'(CAP_MAX));
        set_reg(REG_REL_TOLERANCE, 32'h00FF_FFFF);
        send_interval(-Q_EIGHT, Q_EIGHT);
        drain();
        set_reg(REG_ITERATION_CAP, DATA_W'(ITERATION_CAP_RST));
        set_reg(REG_REL_TOLERANCE, DATA_W'(REL_TOLERANCE_RST));
        set_coefs(Q_MAX, 1'b0);                  // accumulator saturates
        send_interval(Q_MIN, Q_MAX);
        send_interval('0, Q_ONE);
        drain();
        set_coefs(Q_MIN, 1'b0);
        send_interval(Q_MAX, Q_MIN);
        drain();
        set_coefs('0, 1'b0);                     // sign product always zero
        send_interval(-Q_ONE, Q_ONE);
        drain();
        set_reg(REG_UNUSED, $urandom);           // must leave the registers alone
        send_interval(Q_ONE, 2 * Q_ONE);
    endtask

    // Random register sets, each followed by a batch of intervals
    task automatic test_random_polynomials(input int target);
        logic [CAP_W-1:0]         cap;
        logic [TOL_W-1:0]         tol;
        logic signed [DATA_W-1:0] lo_q;
        logic signed [DATA_W-1:0] hi_q;
        int                       sent;
        int                       batch;
        int                       n;
        sent = 0;
        while (sent < target) begin
            drain();
            idling = ($urandom_range(0, 3) != 0);
            set_coefs('0, 1'b1);
            case ($urandom_range(0, 9))
                0: cap = '0;
                1: cap = CAP_W'($urandom_range(65, 127));
                2: cap = CAP_MAX;
                default: cap = CAP_W'($urandom_range(1, SHORT_CAP));
            endcase
            case ($urandom_range(0, 3))
                0: tol = REL_TOLERANCE_RST;
                1: tol = TOL_W'($urandom_range(1, 4096));
                2: tol = TOL_W'($urandom);
                default: tol = (cap <= SHORT_CAP) ? '0 : REL_TOLERANCE_RST;
            endcase
            set_reg(REG_ITERATION_CAP, DATA_W'(cap));
            set_reg(REG_REL_TOLERANCE, DATA_W'(tol));
            // long searches only in short batches
            batch = (cap > SHORT_CAP) ? 20 : $urandom_range(60, 160);
            for (n = 0; n < batch; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        lo_q = $urandom;
                        hi_q = $urandom;
                    end
                    2: begin
                        lo_q = near_q();
                        hi_q = '0;
                    end
                    3: begin
                        lo_q = near_q();
                        hi_q = near_q();
                    end
                    default: begin
                        lo_q = near_q();
                        hi_q = near_q();
                        if (lo_q > hi_q)
                            {lo_q, hi_q} = {hi_q, lo_q};
                    end
                endcase
                send_interval(lo_q, hi_q);
            end
            sent += batch;
        end
    endtask

    // Back-to-back requests with the result side always ready
    task automatic test_steady_stream(input int count);
        int n;
        drain();
        idling = 1'b0;
        set_coefs('0, 1'b1);
        set_reg(REG_ITERATION_CAP, $urandom_range(1, SHORT_CAP));
        set_reg(REG_REL_TOLERANCE, DATA_W'(REL_TOLERANCE_RST));
        for (n = 0; n < count; n++)
            send_interval(near_q(), near_q());
    endtask

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_polynomial();
        test_register_corners();
        test_random_polynomials(1380);
        test_steady_stream(100);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && roots_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
